FILE: sv/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a property that must hold at each rising edge while out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// the consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/trd_pkg.sv
package trd_pkg;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_DRAW  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  localparam int unsigned CFG_WIDTH  = 0;
  localparam int unsigned CFG_HEIGHT = 1;

  localparam logic [12:0] COUNT_MAX = 13'd8191;

  // request to the divider
  typedef struct packed {
    logic        start;
    logic [65:0] num;
    logic [25:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [65:0] quo;
  } div_rsp_t;

endpackage

FILE: sv/triangle_raster_depth_test.sv
// Triangle rasterizer with a z-buffer, one command at a time. A clear writes
// every active pixel in turn. A draw walks the clamped bounding box column
// by column: the edge functions are taken one at a time for each pixel, and
// each covered pixel then runs a bit-serial divide for its depth and a store
// read, with a write if the depth test passes. A read looks up the store at
// accept. Results wait in an output register; the input is not ready while
// a command is in progress. Stores are not cleared at reset.
`include "assert_macros.svh"

module triangle_raster_depth_test #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic signed [11:0] in_x0,
  input  logic signed [11:0] in_y0,
  input  logic signed [11:0] in_x1,
  input  logic signed [11:0] in_y1,
  input  logic signed [11:0] in_x2,
  input  logic signed [11:0] in_y2,
  input  logic [31:0]        in_z0,
  input  logic [31:0]        in_z1,
  input  logic [31:0]        in_z2,
  input  logic [23:0]        in_fill_color,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        out_pixel_color,
  output logic [31:0]        out_pixel_depth,
  output logic [12:0]        out_pixels_written,
  output logic               out_out_of_range
);

  localparam int XW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_CLEAR = 12'b000000000010,
    ST_AREA  = 12'b000000000100,
    ST_PIX   = 12'b000000001000,
    ST_EA    = 12'b000000010000,
    ST_EB    = 12'b000000100000,
    ST_EC    = 12'b000001000000,
    ST_ZA    = 12'b000010000000,
    ST_DIV   = 12'b000100000000,
    ST_TEST  = 12'b001000000000,
    ST_RD    = 12'b010000000000,
    ST_OUT   = 12'b100000000000
  } state_t;

  state_t state_r;

  logic [6:0] wcfg_r, hcfg_r;

  // latched command
  logic signed [12:0] vx0_r, vy0_r, vx1_r, vy1_r, vx2_r, vy2_r;
  logic [31:0] z0_r, z1_r, z2_r;
  logic [23:0] col_r;
  logic [1:0]  mode_r;

  // walk position, wide enough for the clamped box limits
  logic [12:0] px_r, py_r, bx1_r, by0_r, by1_r;
  logic signed [25:0] area_r;     // |A|
  logic               aneg_r;
  logic signed [26:0] sa_r, sb_r, sc_r;
  logic [65:0] sum_r;
  logic [12:0] cnt_r;

  // read result held until the output register takes it
  logic [23:0] rcol_r;
  logic [31:0] rdep_r;
  logic        roor_r;

  logic [23:0] o_col_r;
  logic [31:0] o_dep_r;
  logic [12:0] o_cnt_r;
  logic        o_oor_r;
  logic        out_valid_r;

  // memories
  logic [23:0] cmem [DEPTH];
  logic [31:0] dmem [DEPTH];
  logic [23:0] crd_r;
  logic [31:0] drd_r;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdep;

  trd_pkg::div_req_t dreq;
  trd_pkg::div_rsp_t drsp;

  trd_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // active size clamped to the store
  logic [12:0] aw, ah;
  always_comb begin
    aw = (32'(wcfg_r) > MAX_WIDTH)  ? 13'(MAX_WIDTH)  : 13'(wcfg_r);
    ah = (32'(hcfg_r) > MAX_HEIGHT) ? 13'(MAX_HEIGHT) : 13'(hcfg_r);
  end

  // shared edge-function unit: (bx-ax)*(py-ay) - (px-ax)*(by-ay)
  logic signed [12:0] ex_a, ey_a, ex_b, ey_b, ex_p, ey_p;
  logic signed [26:0] ef;
  always_comb begin
    ex_a = vx0_r; ey_a = vy0_r; ex_b = vx1_r; ey_b = vy1_r;
    ex_p = $signed(px_r); ey_p = $signed(py_r);
    unique case (state_r)
      ST_AREA: begin ex_p = vx2_r; ey_p = vy2_r; end
      ST_EB: begin ex_a = vx1_r; ey_a = vy1_r; ex_b = vx2_r; ey_b = vy2_r; end
      ST_EC: begin ex_a = vx2_r; ey_a = vy2_r; ex_b = vx0_r; ey_b = vy0_r; end
      default: ;
    endcase
    ef = 27'((14'(ex_b) - 14'(ex_a)) * (14'(ey_p) - 14'(ey_a)))
       - 27'((14'(ex_p) - 14'(ex_a)) * (14'(ey_b) - 14'(ey_a)));
  end
  logic signed [26:0] efs;
  assign efs = aneg_r ? -ef : ef;

  // box limits from the latched vertices
  logic signed [12:0] mnx, mxx, mny, mxy;
  always_comb begin
    mnx = vx0_r; if (vx1_r < mnx) mnx = vx1_r; if (vx2_r < mnx) mnx = vx2_r;
    mxx = vx0_r; if (vx1_r > mxx) mxx = vx1_r; if (vx2_r > mxx) mxx = vx2_r;
    mny = vy0_r; if (vy1_r < mny) mny = vy1_r; if (vy2_r < mny) mny = vy2_r;
    mxy = vy0_r; if (vy1_r > mxy) mxy = vy1_r; if (vy2_r > mxy) mxy = vy2_r;
  end

  // one depth product a cycle through the shared multiplier
  logic [1:0]  zsel_r;
  logic [31:0] zm;
  logic [25:0] sm;
  logic [57:0] zprod;
  always_comb begin
    unique case (zsel_r)
      2'd0:    begin zm = z2_r; sm = 26'(sa_r); end
      2'd1:    begin zm = z0_r; sm = 26'(sb_r); end
      default: begin zm = z1_r; sm = 26'(sc_r); end
    endcase
    zprod = zm * sm;
  end

  logic [AW-1:0] paddr;
  assign paddr = AW'(py_r * 13'(MAX_WIDTH) + px_r);

  logic signed [12:0] rx, ry;
  assign rx = vx0_r;
  assign ry = vy0_r;
  logic rd_off;
  assign rd_off = (rx < 0) || (ry < 0) || (rx >= $signed(aw)) || (ry >= $signed(ah));

  logic [31:0] dsat;
  assign dsat = (drsp.quo[65:32] != '0) ? 32'hFFFF_FFFF : drsp.quo[31:0];

  logic [31:0] dq_r;

  logic last_col, last_row;
  assign last_row = (py_r == by1_r);
  assign last_col = (px_r == bx1_r);

  logic walk_end, skip_pix, out_free;
  assign walk_end = last_row && last_col;
  assign skip_pix = (state_r == ST_EA || state_r == ST_EB || state_r == ST_EC) && efs[26];
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    we = 1'b0;
    waddr = paddr;
    raddr = paddr;
    wdep = dq_r;
    dreq.start = 1'b0;
    // last product joins the sum on the way into the divider
    dreq.num = sum_r + 66'(zprod);
    dreq.den = 26'(area_r);
    unique case (state_r)
      ST_CLEAR: begin
        we = (aw != 0) && (ah != 0);
        wdep = z0_r;
      end
      default: ;
    endcase
    if (state_r == ST_ZA && zsel_r == 2'd2) dreq.start = 1'b1;
    if (state_r == ST_TEST && dq_r >= drd_r) we = 1'b1;
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wcfg_r      <= 7'd64;
      hcfg_r      <= 7'd64;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'(trd_pkg::CFG_WIDTH)) wcfg_r <= cfg_data;
        else hcfg_r <= cfg_data;
      end
      if (state_r == ST_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (in_valid) begin
          unique case (in_mode)
            trd_pkg::MODE_CLEAR: state_r <= ST_CLEAR;
            trd_pkg::MODE_DRAW:  state_r <= ST_AREA;
            trd_pkg::MODE_READ:  state_r <= ST_RD;
            default:             state_r <= ST_OUT;
          endcase
        end
        ST_CLEAR: if ((aw == 0) || (ah == 0) ||
                      (px_r == aw - 13'd1 && py_r == ah - 13'd1)) state_r <= ST_OUT;
        ST_AREA: begin
          if (ef == 0 || aw == 0 || ah == 0 ||
              mxx < 0 || mxy < 0 || mnx >= $signed(aw) || mny >= $signed(ah))
            state_r <= ST_OUT;
          else state_r <= ST_PIX;
        end
        ST_PIX: state_r <= ST_EA;
        // a pixel outside moves the walk; the end of the box ends the draw
        ST_EA:  state_r <= efs[26] ? (walk_end ? ST_OUT : ST_PIX) : ST_EB;
        ST_EB:  state_r <= efs[26] ? (walk_end ? ST_OUT : ST_PIX) : ST_EC;
        ST_EC:  state_r <= efs[26] ? (walk_end ? ST_OUT : ST_PIX) : ST_ZA;
        ST_ZA:  if (zsel_r == 2'd2) state_r <= ST_DIV;
        ST_DIV: if (drsp.done) state_r <= ST_TEST;
        ST_TEST: state_r <= walk_end ? ST_OUT : ST_PIX;
        ST_RD:   state_r <= ST_OUT;
        ST_OUT:  if (out_free) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      mode_r <= in_mode;
      vx0_r <= 13'(in_x0); vy0_r <= 13'(in_y0);
      vx1_r <= 13'(in_x1); vy1_r <= 13'(in_y1);
      vx2_r <= 13'(in_x2); vy2_r <= 13'(in_y2);
      z0_r <= in_z0; z1_r <= in_z1; z2_r <= in_z2;
      col_r <= in_fill_color;
      px_r <= '0; py_r <= '0;
      cnt_r <= '0;
      rcol_r <= '0; rdep_r <= '0; roor_r <= 1'b0;
    end
    if (state_r == ST_CLEAR) begin
      if (px_r == aw - 13'd1) begin
        px_r <= '0;
        py_r <= py_r + 13'd1;
      end else px_r <= px_r + 13'd1;
    end
    if (state_r == ST_AREA) begin
      aneg_r <= ef[26];
      area_r <= 26'(ef[26] ? -ef : ef);
      px_r <= (mnx < 0) ? 13'd0 : mnx;
      py_r <= (mny < 0) ? 13'd0 : mny;
      by0_r <= (mny < 0) ? 13'd0 : mny;
      bx1_r <= (mxx >= $signed(aw)) ? aw - 13'd1 : mxx;
      by1_r <= (mxy >= $signed(ah)) ? ah - 13'd1 : mxy;
    end
    if (state_r == ST_PIX) zsel_r <= 2'd0;
    if (state_r == ST_EA) sa_r <= efs;
    if (state_r == ST_EB) sb_r <= efs;
    if (state_r == ST_EC) sc_r <= efs;
    if (state_r == ST_ZA) begin
      zsel_r <= zsel_r + 2'd1;
      sum_r  <= (zsel_r == 2'd0) ? 66'(zprod) : sum_r + 66'(zprod);
    end
    if (state_r == ST_DIV && drsp.done) dq_r <= dsat;
    if (state_r == ST_TEST && dq_r >= drd_r && cnt_r != trd_pkg::COUNT_MAX)
      cnt_r <= cnt_r + 13'd1;
    // a failed pixel or a finished test moves the walk
    if (skip_pix || state_r == ST_TEST) begin
      if (last_row) begin
        py_r <= by0_r;
        px_r <= px_r + 13'd1;
      end else py_r <= py_r + 13'd1;
    end
    if (state_r == ST_RD) begin
      rcol_r <= rd_off ? '0 : crd_r;
      rdep_r <= rd_off ? '0 : drd_r;
      roor_r <= rd_off;
    end
    if (state_r == ST_OUT && out_free) begin
      o_col_r <= rcol_r;
      o_dep_r <= rdep_r;
      o_oor_r <= roor_r;
      o_cnt_r <= (mode_r == trd_pkg::MODE_DRAW) ? cnt_r : '0;
    end
  end

  // read address: pixel being walked, or the requested pixel at accept
  logic [AW-1:0] rdaddr;
  assign rdaddr = (state_r == ST_IDLE) ?
                  AW'(13'(in_y0[YW-1:0]) * 13'(MAX_WIDTH) + 13'(in_x0[XW-1:0])) : raddr;

  always_ff @(posedge clk) begin
    if (we) begin
      cmem[waddr] <= (state_r == ST_CLEAR) ? col_r : col_r;
      dmem[waddr] <= wdep;
    end
    crd_r <= cmem[rdaddr];
    drd_r <= dmem[rdaddr];
  end

  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_pixel_color    = o_col_r;
  assign out_pixel_depth    = o_dep_r;
  assign out_pixels_written = o_cnt_r;
  assign out_out_of_range   = o_oor_r;

  `ASSERT_CLK(a_ready_idle, in_ready == (state_r == ST_IDLE), "ready outside idle")
  `ASSERT_NEXT(a_div_start, dreq.start, drsp.busy, "divider did not start")
  `ASSERT_CLK(a_we_state, !we || state_r == ST_CLEAR || state_r == ST_TEST,
              "store written outside clear or test")

endmodule

FILE: sv/trd_divider.sv
// restoring divider, one quotient bit per cycle
module trd_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  trd_pkg::div_req_t req,
  output trd_pkg::div_rsp_t rsp
);

  logic [65:0] quo_r, quo_nxt;
  logic [26:0] rem_r, rem_nxt;
  logic [25:0] den_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [26:0] trial;
  logic [27:0] diff;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[25:0], quo_r[65]};
    diff     = {1'b0, trial} - {2'b00, den_r};
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      cnt_nxt  = 7'd66;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[27]) begin
        rem_nxt = diff[26:0];
        quo_nxt = {quo_r[64:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[64:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req.start) den_r <= req.den;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule
